// ===== design/lfu_cache_lru_tiebreak_macros.svh =====
// Assertion macros shared by the cache RTL.
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFUC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFUC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lfuc_pkg.sv =====
package lfuc_pkg;

   localparam int CAPACITY    = 16;
   localparam int COUNT_WIDTH = 32;
   localparam int DATA_W      = 32;
   localparam int STAMP_W     = 64;
   localparam int CSR_W       = 5;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W       = $clog2(CAPACITY + 1);

   localparam logic [CSR_W-1:0] CAP_RESET = CSR_W'(16);

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef struct packed {
      logic                   valid;
      logic [DATA_W-1:0]      key;
      logic [DATA_W-1:0]      value;
      logic [COUNT_WIDTH-1:0] count;
      logic [STAMP_W-1:0]     stamp;
   } lfuc_entry_type;

   typedef struct packed {
      logic                   we;
      logic [IDX_W-1:0]       idx;
      logic                   key_we;
      logic [DATA_W-1:0]      key;
      logic                   value_we;
      logic [DATA_W-1:0]      value;
      logic [COUNT_WIDTH-1:0] count;
      logic [STAMP_W-1:0]     stamp;
      logic                   set_valid;
      logic                   kill;
      logic [IDX_W-1:0]       kill_idx;
   } lfuc_wr_type;

   typedef struct packed {
      logic                   hit;
      logic [IDX_W-1:0]       hit_idx;
      logic [COUNT_WIDTH-1:0] hit_count;
      logic [DATA_W-1:0]      hit_value;
      logic                   victim;
      logic [IDX_W-1:0]       victim_idx;
      logic                   free;
      logic [IDX_W-1:0]       free_idx;
   } lfuc_scan_type;

   function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] c);
      return (c == '1) ? c : c + COUNT_WIDTH'(1);
   endfunction

endpackage

// ===== design/lfuc_if.sv =====
interface lfuc_req_if import lfuc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic signed [DATA_W-1:0] key;
   logic signed [DATA_W-1:0] write_value;

   modport source (output valid, func, key, write_value, input ready);
   modport sink (input valid, func, key, write_value, output ready);
endinterface

interface lfuc_rsp_if import lfuc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     found;
   logic signed [DATA_W-1:0] read_value;

   modport source (output valid, found, read_value, input ready);
   modport sink (input valid, found, read_value, output ready);
endinterface

// ===== design/lfuc_table.sv =====
module lfuc_table import lfuc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_idx,
   output lfuc_entry_type   rd_entry,
   input  lfuc_wr_type      wr
);

   logic [CAPACITY-1:0]    valid_ff;
   logic [CAPACITY-1:0]    valid_in;
   logic [DATA_W-1:0]      key_mem   [CAPACITY];
   logic [DATA_W-1:0]      value_mem [CAPACITY];
   logic [COUNT_WIDTH-1:0] count_mem [CAPACITY];
   logic [STAMP_W-1:0]     stamp_mem [CAPACITY];
   lfuc_entry_type         rd_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.kill) begin
         valid_in[wr.kill_idx] = 1'b0;
      end
      if (wr.we && wr.set_valid) begin
         valid_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         if (wr.key_we) begin
            key_mem[wr.idx] <= wr.key;
         end
         if (wr.value_we) begin
            value_mem[wr.idx] <= wr.value;
         end
         count_mem[wr.idx] <= wr.count;
         stamp_mem[wr.idx] <= wr.stamp;
      end
   end

   // The entry addressed in one cycle is presented in the next.
   always_ff @(posedge clock) begin
      rd_ff.valid <= valid_ff[rd_idx];
      rd_ff.key   <= key_mem[rd_idx];
      rd_ff.value <= value_mem[rd_idx];
      rd_ff.count <= count_mem[rd_idx];
      rd_ff.stamp <= stamp_mem[rd_idx];
   end

   assign rd_entry = rd_ff;

endmodule

// ===== design/lfuc_scan.sv =====
module lfuc_scan import lfuc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              step,
   input  logic [IDX_W-1:0]  idx,
   input  logic [DATA_W-1:0] key,
   input  lfuc_entry_type    entry,
   output lfuc_scan_type     status
);

   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic [COUNT_WIDTH-1:0] hit_count_ff;
   logic [DATA_W-1:0]      hit_value_ff;
   logic                   vic_ff, vic_in;
   logic [IDX_W-1:0]       vic_idx_ff;
   logic [COUNT_WIDTH-1:0] vic_count_ff;
   logic [STAMP_W-1:0]     vic_stamp_ff;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_idx_ff;
   logic                   take_hit;
   logic                   take_vic;
   logic                   take_free;

   always_comb begin
      take_hit  = step && entry.valid && !hit_ff && (entry.key == key);
      take_vic  = step && entry.valid &&
                  (!vic_ff || (entry.count < vic_count_ff) ||
                   ((entry.count == vic_count_ff) && (entry.stamp < vic_stamp_ff)));
      take_free = step && !entry.valid && !free_ff;
      hit_in    = start ? 1'b0 : (hit_ff || take_hit);
      vic_in    = start ? 1'b0 : (vic_ff || take_vic);
      free_in   = start ? 1'b0 : (free_ff || take_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         vic_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         vic_ff  <= vic_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_hit) begin
         hit_idx_ff   <= idx;
         hit_count_ff <= entry.count;
         hit_value_ff <= entry.value;
      end
      if (take_vic) begin
         vic_idx_ff   <= idx;
         vic_count_ff <= entry.count;
         vic_stamp_ff <= entry.stamp;
      end
      if (take_free) begin
         free_idx_ff <= idx;
      end
   end

   always_comb begin
      status.hit        = hit_ff;
      status.hit_idx    = hit_idx_ff;
      status.hit_count  = hit_count_ff;
      status.hit_value  = hit_value_ff;
      status.victim     = vic_ff;
      status.victim_idx = vic_idx_ff;
      status.free       = free_ff;
      status.free_idx   = free_idx_ff;
   end

endmodule

// ===== design/lfu_cache_lru_tiebreak.sv =====
// Key-value cache with least-frequently-used replacement and an oldest-touch
// tiebreak. Each item is a get or a put; a get returns one result item with a
// found flag and the stored value, and a put returns nothing. An item is
// accepted while idle; a single shared compare unit then checks each of the
// 16 table entries in turn for a key match, for the eviction victim and for
// the first free slot before write-back. A get waits in write-back while an
// earlier result has not been taken. The capacity register is to be written
// by the user only while the block is idle; the block does not enforce this.
// Values above 16 act as 16 and zero disables the cache.
`include "lfu_cache_lru_tiebreak_macros.svh"

module lfu_cache_lru_tiebreak import lfuc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   lfuc_req_if.sink         req_port,
   lfuc_rsp_if.source       rsp_port,
   input  logic             csr_write_enable,
   input  logic [CSR_W-1:0] csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   func_ff;
   logic [DATA_W-1:0]      key_ff;
   logic [DATA_W-1:0]      wval_ff;
   logic                   en_ff;
   logic [CSR_W-1:0]       csr_capacity_ff;
   logic [STAMP_W-1:0]     touch_ff;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff;
   logic [DATA_W-1:0]      rsp_value_ff;

   logic                   accept;
   logic                   finish;
   logic                   emit;
   logic                   do_hit;
   logic                   do_insert;
   logic                   evict;
   logic                   ins_ok;
   logic [IDX_W-1:0]       ins_idx;
   logic [OCC_W-1:0]       cap_eff;
   lfuc_entry_type         rd_entry;
   lfuc_wr_type            wr;
   lfuc_scan_type          scan;

   lfuc_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (idx_in),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   lfuc_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .step   (state_ff == ST_SCAN),
      .idx    (idx_ff),
      .key    (key_ff),
      .entry  (rd_entry),
      .status (scan)
   );

   assign req_port.ready      = (state_ff == ST_IDLE);
   assign accept              = req_port.valid && req_port.ready;
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.found      = rsp_found_ff;
   assign rsp_port.read_value = rsp_value_ff;

   always_comb begin
      cap_eff = (32'(csr_capacity_ff) > 32'(CAPACITY)) ? OCC_W'(CAPACITY)
                                                       : OCC_W'(csr_capacity_ff);
      finish    = (state_ff == ST_WRITE) &&
                  !((func_ff == FUNC_GET) && rsp_valid_ff && !rsp_port.ready);
      emit      = finish && (func_ff == FUNC_GET);
      do_hit    = en_ff && scan.hit;
      do_insert = en_ff && (func_ff == FUNC_PUT) && !scan.hit;
      evict     = do_insert && (occ_ff >= cap_eff) && scan.victim;
      ins_idx   = (evict && (!scan.free || (scan.victim_idx < scan.free_idx)))
                  ? scan.victim_idx : scan.free_idx;
      ins_ok    = do_insert && (evict || scan.free);

      wr.we        = finish && (do_hit || ins_ok);
      wr.idx       = do_hit ? scan.hit_idx : ins_idx;
      wr.key_we    = !do_hit;
      wr.key       = key_ff;
      wr.value_we  = (func_ff == FUNC_PUT);
      wr.value     = wval_ff;
      wr.count     = do_hit ? count_inc(scan.hit_count) : '0;
      wr.stamp     = touch_ff;
      wr.set_valid = !do_hit;
      wr.kill      = finish && evict;
      wr.kill_idx  = scan.victim_idx;

      occ_in = occ_ff;
      if (finish && ins_ok && !evict) begin
         occ_in = occ_ff + OCC_W'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         idx_ff          <= '0;
         csr_capacity_ff <= CAP_RESET;
         touch_ff        <= '0;
         occ_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         en_ff           <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            csr_capacity_ff <= csr_write_data;
         end
         if (wr.we) begin
            touch_ff <= touch_ff + STAMP_W'(1);
         end
         if (accept) begin
            en_ff <= (csr_capacity_ff != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_port.func;
         key_ff  <= req_port.key;
         wval_ff <= req_port.write_value;
      end
      if (emit) begin
         rsp_found_ff <= do_hit;
         rsp_value_ff <= do_hit ? scan.hit_value : '0;
      end
   end

   `LFUC_ASSERT_SAME(a_occ_bound, clock, reset, 1'b1,
      32'(occ_ff) <= 32'(CAPACITY), "occupancy above table size")
   `LFUC_ASSERT_SAME(a_rsp_from_write, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_WRITE, "result item raised outside write-back")
   `LFUC_ASSERT_NEXT(a_touch_only_on_write, clock, reset, state_ff != ST_WRITE,
      $stable(touch_ff), "touch counter moved outside write-back")
   `LFUC_ASSERT_NEXT(a_put_no_result, clock, reset,
      (state_ff == ST_WRITE) && (func_ff == FUNC_PUT) && !rsp_valid_ff,
      !rsp_valid_ff, "put produced a result item")

endmodule

// ===== tb/sv/lfu_cache_lru_tiebreak_tb.sv =====
`timescale 1ns / 1ps

module lfu_cache_lru_tiebreak_tb;
   import lfuc_pkg::*;

   localparam logic [31:0] KEY_MIN       = 32'h8000_0000;
   localparam logic [31:0] KEY_MAX       = 32'h7fff_ffff;
   localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          POOL_SIZE     = 24;
   localparam int          SEG_ITEMS     = 64;

   typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_CAP} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic         func;
      logic [31:0]  key;
      logic [31:0]  data;
      logic         exp_found;
      logic [31:0]  exp_value;
   } stim_row_type;

   typedef struct {
      logic        found;
      logic [31:0] value;
   } get_result_type;

   logic clock;
   logic reset;
   logic             csr_write_enable;
   logic [CSR_W-1:0] csr_write_data;

   lfuc_req_if req_if();
   lfuc_rsp_if rsp_if();

   lfu_cache_lru_tiebreak dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_if),
      .rsp_port         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the cache table.
   logic                   cm_valid [CAPACITY];
   logic [31:0]            cm_key   [CAPACITY];
   logic [31:0]            cm_value [CAPACITY];
   logic [COUNT_WIDTH-1:0] cm_count [CAPACITY];
   logic [STAMP_W-1:0]     cm_stamp [CAPACITY];
   logic [STAMP_W-1:0]     cm_touch;
   int unsigned            cm_occ;
   int unsigned            cm_cap;

   get_result_type pending_gets [$];
   logic [31:0] key_pool [POOL_SIZE];
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned error_count;

   stim_row_type dir_rows [26] = '{
      '{ROW_CHECKED, FUNC_GET, KEY_MIN,      32'h0,        1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_PUT, KEY_MIN,      KEY_MAX,      1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_PUT, KEY_MAX,      KEY_MIN,      1'b0, 32'h0},
      '{ROW_CHECKED, FUNC_GET, KEY_MIN,      32'h0,        1'b1, KEY_MAX},
      '{ROW_CHECKED, FUNC_GET, KEY_MAX,      ALL_ONES,     1'b1, KEY_MIN},
      '{ROW_ITEM,    FUNC_PUT, 32'h0,        32'h0,        1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_PUT, ALL_ONES,     ALL_ONES,     1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_PUT, KEY_MIN,      32'h1234_5678, 1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_GET, KEY_MIN,      32'h0,        1'b0, 32'h0},
      '{ROW_CAP,     FUNC_GET, 32'h0,        32'd2,        1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_PUT, 32'd5,        32'd5,        1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_GET, 32'h0,        32'h0,        1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_GET, ALL_ONES,     32'h0,        1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_GET, 32'd5,        32'h0,        1'b0, 32'h0},
      '{ROW_CAP,     FUNC_GET, 32'h0,        32'd0,        1'b0, 32'h0},
      '{ROW_CHECKED, FUNC_GET, KEY_MAX,      32'h0,        1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_PUT, 32'd7,        32'd7,        1'b0, 32'h0},
      '{ROW_CHECKED, FUNC_GET, 32'd7,        32'h0,        1'b0, 32'h0},
      '{ROW_CAP,     FUNC_GET, 32'h0,        32'd31,       1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_GET, KEY_MAX,      32'h0,        1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_GET, 32'd7,        32'h0,        1'b0, 32'h0},
      '{ROW_CAP,     FUNC_GET, 32'h0,        32'd1,        1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_PUT, 32'd9,        32'd9,        1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_GET, 32'd9,        32'h0,        1'b0, 32'h0},
      '{ROW_ITEM,    FUNC_GET, 32'd5,        32'h0,        1'b0, 32'h0},
      '{ROW_CAP,     FUNC_GET, 32'h0,        32'd16,       1'b0, 32'h0}
   };

   function automatic void touch_entry(input int slot, input bit bump);
      if (bump && cm_count[slot] != '1)
         cm_count[slot] = cm_count[slot] + 1'b1;
      cm_stamp[slot] = cm_touch;
      cm_touch = cm_touch + 1'b1;
   endfunction

   task automatic cache_apply(input logic func, input logic [31:0] key,
                              input logic [31:0] wval, output bit gives_rsp,
                              output get_result_type res);
      int limit;
      int slot;
      int victim;
      limit = (cm_cap > CAPACITY) ? CAPACITY : int'(cm_cap);
      res.found = 1'b0;
      res.value = 32'h0;
      gives_rsp = (func == FUNC_GET);
      if (limit == 0)
         return;
      slot = -1;
      for (int i = 0; i < CAPACITY; i++)
         if (slot < 0 && cm_valid[i] && cm_key[i] == key)
            slot = i;
      if (func == FUNC_GET) begin
         if (slot >= 0) begin
            touch_entry(slot, 1'b1);
            res.found = 1'b1;
            res.value = cm_value[slot];
         end
         return;
      end
      if (slot >= 0) begin
         cm_value[slot] = wval;
         touch_entry(slot, 1'b1);
         return;
      end
      if (cm_occ >= limit) begin
         victim = -1;
         for (int i = 0; i < CAPACITY; i++) begin
            if (cm_valid[i] && (victim < 0 || cm_count[i] < cm_count[victim] ||
                (cm_count[i] == cm_count[victim] && cm_stamp[i] < cm_stamp[victim])))
               victim = i;
         end
         if (victim >= 0) begin
            cm_valid[victim] = 1'b0;
            if (cm_occ > 0)
               cm_occ--;
         end
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (!cm_valid[i]) begin
            cm_valid[i] = 1'b1;
            cm_key[i]   = key;
            cm_value[i] = wval;
            cm_count[i] = '0;
            touch_entry(i, 1'b0);
            cm_occ++;
            break;
         end
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s at %0t: got %h, expected %h", field, $realtime, got, want);
      error_count++;
   endtask

   task automatic send_item(input stim_row_type row);
      int gap;
      bit gives_rsp;
      get_result_type res;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.func        <= row.func;
      req_if.key         <= row.key;
      req_if.write_value <= row.data;
      do
         @(posedge clock);
      while (!(req_if.valid && req_if.ready));
      cache_apply(row.func, row.key, row.data, gives_rsp, res);
      if (gives_rsp) begin
         if (row.kind == ROW_CHECKED) begin
            res.found = row.exp_found;
            res.value = row.exp_value;
         end
         pending_gets.push_back(res);
      end
   endtask

   task automatic drain_block();
      req_if.valid <= 1'b0;
      while (pending_gets.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CSR_W-1:0] cap);
      drain_block();
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cm_cap = cap;
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      get_result_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_gets.size() == 0) begin
               report_mismatch("unexpected result", {31'b0, rsp_if.found},
                               rsp_if.read_value);
            end else begin
               want = pending_gets.pop_front();
               if (rsp_if.found !== want.found)
                  report_mismatch("found", {31'b0, rsp_if.found}, {31'b0, want.found});
               if (rsp_if.read_value !== want.value)
                  report_mismatch("read_value", rsp_if.read_value, want.value);
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      stim_row_type row;
      int unsigned cap_now;
      int unsigned span;
      error_count   = 0;
      send_idle_pct = 8;
      recv_idle_pct = 49;
      for (int i = 0; i < CAPACITY; i++) begin
         cm_valid[i] = 1'b0;
         cm_key[i]   = '0;
         cm_value[i] = '0;
         cm_count[i] = '0;
         cm_stamp[i] = '0;
      end
      cm_touch = '0;
      cm_occ   = 0;
      cm_cap   = CAP_RESET;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      req_if.valid       <= 1'b0;
      req_if.func        <= FUNC_GET;
      req_if.key         <= '0;
      req_if.write_value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CAP)
            set_capacity(dir_rows[r].data[CSR_W-1:0]);
         else
            send_item(dir_rows[r]);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 49 : 0;
         recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 8 : 0;
         for (int seg = 0; seg < 6; seg++) begin
            case (seg)
               0: cap_now = 16;
               1: cap_now = $urandom_range(6, 2);
               2: cap_now = 31;
               3: cap_now = 1;
               4: cap_now = (phase == 1) ? 0 : $urandom_range(31, 0);
               default: cap_now = $urandom_range(15, 8);
            endcase
            set_capacity(cap_now[CSR_W-1:0]);
            repeat (6)
               key_pool[$urandom_range(POOL_SIZE - 1, 0)] = $urandom;
            span = (cap_now > CAPACITY) ? CAPACITY + 3 : cap_now + 3;
            if (span > POOL_SIZE)
               span = POOL_SIZE;
            repeat (SEG_ITEMS) begin
               row.kind      = ROW_ITEM;
               row.func      = $urandom_range(1, 0) ? FUNC_PUT : FUNC_GET;
               row.key       = ($urandom_range(99) < 85) ?
                               key_pool[$urandom_range(span - 1, 0)] : $urandom;
               row.data      = $urandom;
               row.exp_found = 1'b0;
               row.exp_value = '0;
               send_item(row);
            end
         end
      end

      drain_block();
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
